// ----- sv/sst_pkg.sv -----
package sst_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		CMD_INSERT    = 4'd0,
		CMD_REMOVE    = 4'd1,
		CMD_MEMBER    = 4'd2,
		CMD_CLEAR     = 4'd3,
		CMD_COPY      = 4'd4,
		CMD_INTERSECT = 4'd5,
		CMD_SUBTRACT  = 4'd6,
		CMD_UNION     = 4'd7,
		CMD_EQUAL     = 4'd8,
		CMD_SUBSET    = 4'd9,
		CMD_READ      = 4'd10
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PAIR_RD,
		ST_PAIR_CMP,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_COPY_RD_W,
		ST_DONE
	} state_t;

	// Signed order compare on raw words.
	function automatic logic key_lt(input logic [31:0] x, input logic [31:0] y);
		key_lt = $signed(x) < $signed(y);
	endfunction

endpackage

// ----- sv/sorted_set_table.sv -----
// Read, clear, unused codes and equal on unequal counts go straight to the final step;
// member runs a binary search; insert and remove also shift entries one at a time;
// merges, equal and subset walk both sets pair by pair, and merges and copy write the
// elements back one at a time. One request at a time: busy drops in the cycle of the
// result strobe, which the receiver cannot stall. Reset empties both sets at once.
module sorted_set_table import sst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  cmd,
	input  logic        which_set,
	input  logic signed [31:0] value,
	input  logic [5:0]  index,
	output logic        done,
	output logic        answer,
	output logic [6:0]  count_after,
	output logic signed [31:0] element,
	output logic        element_valid,
	output logic        overflow
);

	// Three memories: set A, set B and the merge scratch. Each step but the last reads
	// at most one address of each memory and writes at most one; reads are registered.
	logic [31:0] mem_a [CAPACITY];
	logic [31:0] mem_b [CAPACITY];
	logic [31:0] mem_s [CAPACITY];

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic   tb_q;
	logic [31:0] val_q;
	logic [5:0]  idx_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] i_q, j_q, k_q, lo_q, hi_q;
	logic [31:0] rd_t_q, rd_o_q, rd_s_q;
	logic ans_q, ovf_q, eval_q;
	logic [31:0] elem_q;

	// Read addresses and write ports chosen by the sequencer.
	logic [AW-1:0] addr_t, addr_o, addr_s;
	logic          we_t, we_s;
	logic [AW-1:0] waddr_t, waddr_s;
	logic [31:0]   wdata_t, wdata_s;

	logic [CW-1:0] n, m, mid;
	assign n = tb_q ? cnt_b_q : cnt_a_q;
	assign m = tb_q ? cnt_a_q : cnt_b_q;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Counts of the sets named by an incoming request.
	logic [CW-1:0] cnt_t_in, cnt_o_in;
	assign cnt_t_in = which_set ? cnt_b_q : cnt_a_q;
	assign cnt_o_in = which_set ? cnt_a_q : cnt_b_q;

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (we_t) begin
			if (tb_q) mem_b[waddr_t] <= wdata_t;
			else mem_a[waddr_t] <= wdata_t;
		end
		if (we_s) mem_s[waddr_s] <= wdata_s;
		rd_t_q <= tb_q ? mem_b[addr_t] : mem_a[addr_t];
		rd_o_q <= tb_q ? mem_a[addr_o] : mem_b[addr_o];
		rd_s_q <= mem_s[addr_s];
	end

	// Pair step decisions for merge, equal and subset walks.
	logic t_lt, o_lt, eq;
	assign t_lt = key_lt(rd_t_q, rd_o_q);
	assign o_lt = key_lt(rd_o_q, rd_t_q);
	assign eq = (rd_t_q == rd_o_q);

	logic [CW-1:0] i_d, j_d, k_d, lo_d, hi_d;
	logic ans_d, ovf_d, set_cnt;
	logic [CW-1:0] new_cnt;
	logic emit;
	logic [31:0] emit_val;

	always_comb begin
		state_d = state_q;
		i_d = i_q; j_d = j_q; k_d = k_q; lo_d = lo_q; hi_d = hi_q;
		ans_d = ans_q; ovf_d = ovf_q;
		set_cnt = 1'b0; new_cnt = n;
		addr_t = mid[AW-1:0]; addr_o = j_q[AW-1:0]; addr_s = k_q[AW-1:0];
		we_t = 1'b0; waddr_t = i_q[AW-1:0]; wdata_t = rd_t_q;
		we_s = 1'b0; waddr_s = k_q[AW-1:0]; wdata_s = rd_t_q;
		emit = 1'b0; emit_val = rd_t_q;
		unique case (state_q)
			ST_IDLE: begin
				// A request picks its walk; equal on unequal counts is decided at once.
				if (start) begin
					unique case (cmd)
						CMD_INSERT, CMD_REMOVE, CMD_MEMBER: state_d = ST_SRCH_RD;
						CMD_INTERSECT, CMD_SUBTRACT, CMD_UNION, CMD_SUBSET:
							state_d = ST_PAIR_RD;
						CMD_EQUAL: state_d = (cnt_t_in == cnt_o_in) ? ST_PAIR_RD : ST_DONE;
						CMD_COPY: state_d = ST_COPY_WR;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SRCH_RD: begin
				addr_t = mid[AW-1:0];
				if (lo_q < hi_q) state_d = ST_SRCH_CMP;
				else begin
					addr_t = lo_q[AW-1:0];
					state_d = ST_SHIFT_RD;
					i_d = lo_q;
				end
			end
			ST_SRCH_CMP: begin
				if (key_lt(rd_t_q, val_q)) lo_d = mid + 1'b1;
				else hi_d = mid;
				state_d = ST_SRCH_RD;
			end
			ST_SHIFT_RD: begin
				// rd_t_q holds entry at the found position.
				state_d = ST_DONE;
				unique case (cmd_q)
					CMD_MEMBER: ans_d = (i_q < n) && (rd_t_q == val_q);
					CMD_INSERT: begin
						if (!((i_q < n) && (rd_t_q == val_q))) begin
							if (n >= CW'(CAPACITY)) ovf_d = 1'b1;
							else begin
								i_d = n;
								state_d = ST_SHIFT_WR;
							end
						end
					end
					default: begin
						if ((i_q < n) && (rd_t_q == val_q)) begin
							i_d = i_q;
							state_d = ST_SHIFT_WR;
						end
					end
				endcase
			end
			ST_SHIFT_WR: begin
				// Insert walks down from the count, remove walks up from the hit.
				if (cmd_q == CMD_INSERT) begin
					if (i_q == lo_q) begin
						we_t = 1'b1; waddr_t = i_q[AW-1:0]; wdata_t = val_q;
						set_cnt = 1'b1; new_cnt = n + 1'b1;
						state_d = ST_DONE;
					end else begin
						addr_t = AW'(i_q - 1'b1);
						state_d = ST_COPY_RD;
					end
				end else begin
					if (i_q + 1'b1 >= n) begin
						set_cnt = 1'b1; new_cnt = n - 1'b1;
						state_d = ST_DONE;
					end else begin
						addr_t = AW'(i_q + 1'b1);
						state_d = ST_COPY_RD;
					end
				end
			end
			ST_COPY_RD: begin
				// One-entry move for insert/remove shifts.
				we_t = 1'b1; waddr_t = i_q[AW-1:0]; wdata_t = rd_t_q;
				i_d = (cmd_q == CMD_INSERT) ? i_q - 1'b1 : i_q + 1'b1;
				state_d = ST_SHIFT_WR;
			end
			ST_PAIR_RD: begin
				addr_t = i_q[AW-1:0]; addr_o = j_q[AW-1:0];
				state_d = ST_PAIR_CMP;
				if (cmd_q == CMD_SUBSET) begin
					if (i_q >= n) state_d = ST_DONE;
				end else if (cmd_q == CMD_EQUAL) begin
					if (i_q >= n) state_d = ST_DONE;
				end else if (i_q >= n && j_q >= m) begin
					i_d = '0; state_d = ST_COPY_WR; addr_s = '0;
				end
			end
			ST_PAIR_CMP: begin
				state_d = ST_PAIR_RD;
				unique case (cmd_q)
					CMD_EQUAL: begin
						if (!eq) begin ans_d = 1'b0; state_d = ST_DONE; end
						i_d = i_q + 1'b1;
						j_d = j_q + 1'b1;
					end
					CMD_SUBSET: begin
						if (j_q >= m || t_lt) begin
							ans_d = 1'b0; state_d = ST_DONE;
						end else begin
							if (eq) i_d = i_q + 1'b1;
							j_d = j_q + 1'b1;
						end
					end
					default: begin
						if (j_q >= m || (i_q < n && t_lt)) begin
							emit_val = rd_t_q; emit = (cmd_q != CMD_INTERSECT);
							i_d = i_q + 1'b1;
						end else if (i_q >= n || o_lt) begin
							emit_val = rd_o_q; emit = (cmd_q == CMD_UNION);
							j_d = j_q + 1'b1;
						end else begin
							emit_val = rd_t_q; emit = (cmd_q != CMD_SUBTRACT);
							i_d = i_q + 1'b1; j_d = j_q + 1'b1;
						end
						if (emit) begin
							if (k_q >= CW'(CAPACITY)) begin
								ovf_d = 1'b1; i_d = '0;
								state_d = ST_COPY_WR; addr_s = '0;
							end else begin
								we_s = 1'b1; wdata_s = emit_val; k_d = k_q + 1'b1;
							end
						end
					end
				endcase
			end
			ST_COPY_WR: begin
				// Copy scratch (merge) or operand (copy) into the target,
				// one read then one write per entry.
				addr_s = i_q[AW-1:0]; addr_o = i_q[AW-1:0];
				if (i_q >= k_q) begin
					set_cnt = 1'b1; new_cnt = k_q; state_d = ST_DONE;
				end else state_d = ST_COPY_RD_W;
			end
			ST_COPY_RD_W: begin
				we_t = 1'b1; waddr_t = i_q[AW-1:0];
				wdata_t = (cmd_q == CMD_COPY) ? rd_o_q : rd_s_q;
				i_d = i_q + 1'b1;
				addr_s = AW'(i_q + 1'b1); addr_o = AW'(i_q + 1'b1);
				state_d = ST_COPY_WR;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (start && !busy) begin
				if (cmd == CMD_CLEAR) begin
					if (which_set) cnt_b_q <= '0;
					else cnt_a_q <= '0;
				end
			end else if (set_cnt) begin
				if (tb_q) cnt_b_q <= new_cnt;
				else cnt_a_q <= new_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd_t'(cmd);
			tb_q <= which_set;
			val_q <= value;
			idx_q <= index;
			lo_q <= '0;
			hi_q <= cnt_t_in;
			i_q <= '0;
			j_q <= '0;
			k_q <= (cmd == CMD_COPY) ? cnt_o_in : '0;
			ovf_q <= 1'b0;
			// Equal starts true only when both counts match; subset starts true.
			ans_q <= (cmd == CMD_SUBSET) || ((cmd == CMD_EQUAL) && (cnt_t_in == cnt_o_in));
			eval_q <= 1'b0;
		end else begin
			i_q <= i_d; j_q <= j_d; k_q <= k_d; lo_q <= lo_d; hi_q <= hi_d;
			ans_q <= ans_d; ovf_q <= ovf_d;
			if (state_q == ST_DONE && cmd_q == CMD_READ)
				eval_q <= ({1'b0, idx_q} < n);
		end
	end

	// Read command: fetch the entry at the index on the final step.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE)
			elem_q <= tb_q ? mem_b[idx_q] : mem_a[idx_q];
	end

	assign answer = ans_q && (cmd_q == CMD_MEMBER || cmd_q == CMD_EQUAL ||
		cmd_q == CMD_SUBSET);
	assign count_after = 7'(n);
	assign element_valid = eval_q;
	assign element = eval_q ? elem_q : '0;
	assign overflow = ovf_q;

`ifndef SYNTHESIS
	// A set never holds more than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= CW'(CAPACITY) && cnt_b_q <= CW'(CAPACITY))
		else $error("set count beyond capacity");
	// The result strobe follows the last sequencer step.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE))
		else $error("result strobe without final step");
	// No request is taken while a result is being produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> busy)
		else $error("not busy during final step");
`endif

endmodule

// ----- tb/tb_sorted_set_table.sv -----
module tb_sorted_set_table;
	import sst_pkg::*;

	// Clock, reset and the block's ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] cmd = 4'd0;
	logic which_set = 1'b0;
	logic signed [31:0] value = 32'sd0;
	logic [5:0] index = 6'd0;
	logic done;
	logic answer;
	logic [6:0] count_after;
	logic signed [31:0] element;
	logic element_valid;
	logic overflow;

	always #10 clk = ~clk;

	sorted_set_table DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .which_set(which_set), .value(value), .index(index),
		.done(done), .answer(answer), .count_after(count_after),
		.element(element), .element_valid(element_valid), .overflow(overflow)
	);

	// One result of a request, as the block reports it.
	typedef struct packed {
		logic        answer;
		logic [6:0]  count_after;
		logic [31:0] element;
		logic        element_valid;
		logic        overflow;
	} set_result_t;

	// One row of the directed table. A row with a typed-in result is checked
	// against it as well as against the predictor.
	typedef struct {
		logic [3:0]  op;
		logic        tgt;
		logic [31:0] val;
		logic [5:0]  idx;
		logic        typed;
		set_result_t want;
	} table_row_t;

	// The predictor's own copy of both sets, kept as sorted queues.
	logic signed [31:0] mirror_set [2][$];
	set_result_t pending_results [$];

	int fail_count = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int cycle_count = 0;
	int op_hits [16];
	int overflow_hits = 0;
	int sender_idle_pct = 0;

	// Computes the result of one request and updates the mirror sets. The
	// merges walk both sorted sets in step, as the block does, and stop at
	// capacity with the overflow flag.
	function automatic set_result_t predict_set_op(input logic [3:0] op, input logic tgt,
			input logic signed [31:0] val, input logic [5:0] idx);
		set_result_t r;
		logic signed [31:0] t [$];
		logic signed [31:0] o [$];
		logic signed [31:0] merged [$];
		int i, j, p;
		logic emit, take_t;
		logic signed [31:0] e;
		r = '0;
		t = mirror_set[tgt];
		o = mirror_set[!tgt];
		i = 0;
		j = 0;
		p = 0;
		case (op)
			CMD_INSERT, CMD_REMOVE, CMD_MEMBER: begin
				while (p < t.size() && t[p] < val) p++;
				if (op == CMD_MEMBER) begin
					r.answer = (p < t.size() && t[p] == val);
				end else if (op == CMD_REMOVE) begin
					if (p < t.size() && t[p] == val) t.delete(p);
				end else if (!(p < t.size() && t[p] == val)) begin
					if (t.size() >= CAPACITY) r.overflow = 1'b1;
					else t.insert(p, val);
				end
			end
			CMD_CLEAR: t = {};
			CMD_COPY: t = o;
			CMD_INTERSECT, CMD_SUBTRACT, CMD_UNION: begin
				while (i < t.size() || j < o.size()) begin
					if (j >= o.size() || (i < t.size() && t[i] < o[j])) begin
						e = t[i]; i++; emit = (op != CMD_INTERSECT);
					end else if (i >= t.size() || t[i] > o[j]) begin
						e = o[j]; j++; emit = (op == CMD_UNION);
					end else begin
						e = t[i]; i++; j++; emit = (op != CMD_SUBTRACT);
					end
					if (emit) begin
						if (merged.size() >= CAPACITY) begin
							r.overflow = 1'b1;
							break;
						end
						merged.push_back(e);
					end
				end
				t = merged;
			end
			CMD_EQUAL: begin
				r.answer = (t.size() == o.size());
				if (r.answer) begin
					foreach (t[q]) if (t[q] != o[q]) r.answer = 1'b0;
				end
			end
			CMD_SUBSET: begin
				r.answer = 1'b1;
				foreach (t[q]) begin
					take_t = 1'b0;
					foreach (o[s]) if (o[s] == t[q]) take_t = 1'b1;
					if (!take_t) r.answer = 1'b0;
				end
			end
			CMD_READ: begin
				if (idx < t.size()) begin
					r.element = t[idx];
					r.element_valid = 1'b1;
				end
			end
			default: ;
		endcase
		mirror_set[tgt] = t;
		r.count_after = 7'(t.size());
		return r;
	endfunction

	// Waits at a falling edge until the block is free, idles a while, then
	// drives one request for exactly one cycle so it is taken at the next
	// rising edge. The result is predicted here, before the block can answer.
	task automatic send_request(input logic [3:0] op, input logic tgt,
			input logic [31:0] val, input logic [5:0] idx, output set_result_t predicted);
		while (busy) @(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
		cmd <= op;
		which_set <= tgt;
		value <= val;
		index <= idx;
		start <= 1'b1;
		predicted = predict_set_op(op, tgt, val, idx);
		pending_results.push_back(predicted);
		op_hits[op]++;
		if (predicted.overflow) overflow_hits++;
		@(negedge clk);
		start <= 1'b0;
		requests_sent++;
	endtask

	// Result checker: every strobe is compared with the oldest prediction.
	always @(posedge clk) begin
		set_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no request waiting");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (answer !== want.answer) begin
					$error("answer: expected %0d, got %0d", want.answer, answer);
					fail_count++;
				end
				if (count_after !== want.count_after) begin
					$error("count_after: expected %0d, got %0d", want.count_after, count_after);
					fail_count++;
				end
				if (element !== want.element) begin
					$error("element: expected %0d, got %0d", $signed(want.element), element);
					fail_count++;
				end
				if (element_valid !== want.element_valid) begin
					$error("element_valid: expected %0d, got %0d", want.element_valid,
						element_valid);
					fail_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, overflow);
					fail_count++;
				end
			end
		end
	end

	// Watchdog. The limit allows for the slowest request on every request and the idle gaps.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Picks a value from a small pool most of the time so that sets overlap
	// and hits are common, and from the full range or its two extremes otherwise.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(80)) - 40;
		endcase
	endfunction

	table_row_t directed [$];
	set_result_t got;

	initial begin
		table_row_t row;
		logic [3:0] op;
		int k, pick;

		// Directed table: empty-set behavior, extremes of value, every command,
		// duplicates, absent removes, reads past the count and unused codes.
		directed = '{
			'{CMD_READ,      1'b0, 32'h0,        6'd0,  1'b1,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_MEMBER,    1'b1, 32'h0,        6'd0,  1'b1,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_EQUAL,     1'b0, 32'h0,        6'd0,  1'b1,
				'{1'b1, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_SUBSET,    1'b1, 32'h0,        6'd0,  1'b1,
				'{1'b1, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_INSERT,    1'b0, 32'h7fffffff, 6'd0,  1'b1,
				'{1'b0, 7'd1, 32'h0, 1'b0, 1'b0}},
			'{CMD_INSERT,    1'b0, 32'h80000000, 6'd0,  1'b1,
				'{1'b0, 7'd2, 32'h0, 1'b0, 1'b0}},
			'{CMD_INSERT,    1'b0, 32'h80000000, 6'd0,  1'b1,
				'{1'b0, 7'd2, 32'h0, 1'b0, 1'b0}},
			'{CMD_INSERT,    1'b0, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_READ,      1'b0, 32'h0,        6'd0,  1'b1,
				'{1'b0, 7'd3, 32'h80000000, 1'b1, 1'b0}},
			'{CMD_READ,      1'b0, 32'h0,        6'd63, 1'b1,
				'{1'b0, 7'd3, 32'h0, 1'b0, 1'b0}},
			'{CMD_MEMBER,    1'b0, 32'h7fffffff, 6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_REMOVE,    1'b0, 32'd5,        6'd0,  1'b1,
				'{1'b0, 7'd3, 32'h0, 1'b0, 1'b0}},
			'{CMD_INSERT,    1'b1, 32'd5,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_INSERT,    1'b1, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_SUBSET,    1'b1, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_UNION,     1'b1, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_SUBSET,    1'b0, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_INTERSECT, 1'b0, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_SUBTRACT,  1'b1, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_COPY,      1'b0, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_EQUAL,     1'b0, 32'h0,        6'd0,  1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{4'd11,         1'b0, 32'hffffffff, 6'd42, 1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{4'd15,         1'b1, 32'h0,        6'd21, 1'b0,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_CLEAR,     1'b0, 32'h0,        6'd0,  1'b1,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}},
			'{CMD_CLEAR,     1'b1, 32'h0,        6'd0,  1'b1,
				'{1'b0, 7'd0, 32'h0, 1'b0, 1'b0}}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[r]) begin
			row = directed[r];
			send_request(row.op, row.tgt, row.val, row.idx, got);
			if (row.typed && got !== row.want) begin
				$error("table row %0d: predictor disagrees with typed-in result", r);
				fail_count++;
			end
		end

		// Fill both sets to capacity and push a union past it, so that the
		// full-set insert and the truncated union are both reached.
		for (k = 0; k < CAPACITY; k++)
			send_request(CMD_INSERT, 1'b0, 32'(2 * k), 6'd0, got);
		for (k = 0; k < CAPACITY; k++)
			send_request(CMD_INSERT, 1'b1, 32'(2 * k + 1), 6'd0, got);
		send_request(CMD_INSERT, 1'b0, 32'h7fffffff, 6'd0, got);
		send_request(CMD_READ, 1'b1, 32'd0, 6'd63, got);
		send_request(CMD_UNION, 1'b0, 32'd0, 6'd0, got);
		send_request(CMD_CLEAR, 1'b0, 32'd0, 6'd0, got);
		send_request(CMD_CLEAR, 1'b1, 32'd0, 6'd0, got);

		// Random part in three idle phases. Inserts dominate so that the sets
		// grow; clears now and then keep them from sitting at capacity.
		for (k = 0; k < 1350; k++) begin
			sender_idle_pct = (k < 450) ? 15 : (k < 900) ? 54 : 0;
			pick = $urandom_range(99);
			if (pick < 35) op = CMD_INSERT;
			else if (pick < 45) op = CMD_REMOVE;
			else if (pick < 55) op = CMD_MEMBER;
			else if (pick < 57) op = CMD_CLEAR;
			else if (pick < 97) op = 4'($urandom_range(4, 10));
			else op = 4'($urandom_range(11, 15));
			send_request(op, 1'($urandom_range(1)), pick_value(), 6'($urandom_range(63)), got);
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests, %0d results checked, %0d truncated at capacity.",
			requests_sent, results_seen, overflow_hits);
		$display("Unions %0d, intersects %0d, subtracts %0d, reads %0d.",
			op_hits[CMD_UNION], op_hits[CMD_INTERSECT], op_hits[CMD_SUBTRACT],
			op_hits[CMD_READ]);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/sst_pkg.sv
sv/sorted_set_table.sv
tb/tb_sorted_set_table.sv
